// ===== rtl/gwdm_pkg.sv =====
// Shared types, constants and helpers for the walkable direction mask block.
// No dependencies.
`timescale 1ns / 1ps

package gwdm_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COORD_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_W       = 8;
    localparam int QUEUE_DEPTH = 4;   // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 9'd16;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 9'd16;

    typedef enum logic {
        KIND_CELL  = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    // one column step for the back end
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic               walk;
        logic               emit;
        logic               has_l;
        logic               has_r;
        logic               has_d;
        logic               has_u;
        logic               last;
        logic [COORD_W-1:0] ox;
        logic [ROW_W-1:0]   oy;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // size minus one, with 0 taken as 1 and anything above lim taken as lim
    function automatic int unsigned clamp_m1(input logic [CFG_W-1:0] v,
                                             input int unsigned lim);
        int unsigned r;
        if (v == '0)
            r = 0;
        else if (32'(v) > lim)
            r = lim - 1;
        else
            r = 32'(v) - 32'd1;
        return r;
    endfunction

endpackage

// ===== rtl/gwdm_front.sv =====
// Front end: size registers, raster and result position counters, word classification.
// Depends on gwdm_pkg.
`timescale 1ns / 1ps

module gwdm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gwdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gwdm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic                          walkable,
    input  gwdm_pkg::q_status_t           q_status,
    output logic                          push,
    output gwdm_pkg::op_t                 push_op
);
    import gwdm_pkg::*;

    logic [COORD_W-1:0] w_m1_reg, w_m1_next;
    logic [ROW_W-1:0]   h_m1_reg, h_m1_next;
    logic [COORD_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [COORD_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic               full_reg, full_next;
    logic               prime_reg, prime_next;

    logic               accept;
    logic               col_wrap;
    logic [COORD_W-1:0] col_inc;
    logic               emit_cell;
    logic [COORD_W-1:0] out_col_adv;
    logic [ROW_W-1:0]   out_row_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg    <= COORD_W'(clamp_m1(GRID_WIDTH_RESET, MAX_WIDTH));
            h_m1_reg    <= ROW_W'(clamp_m1(GRID_HEIGHT_RESET, MAX_HEIGHT));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            full_reg    <= 1'b0;
            prime_reg   <= 1'b0;
        end
        else
        begin
            w_m1_reg    <= w_m1_next;
            h_m1_reg    <= h_m1_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            full_reg    <= full_next;
            prime_reg   <= prime_next;
        end
    end

    always_comb
    begin
        w_m1_next    = w_m1_reg;
        h_m1_next    = h_m1_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        full_next    = full_reg;
        prime_next   = prime_reg;

        in_ready = !q_status.full && !prime_reg;
        accept   = in_valid && in_ready;
        col_wrap = (in_col_reg == w_m1_reg);
        col_inc  = col_wrap ? '0 : COORD_W'(in_col_reg + 1'b1);
        // a cell completes a neighborhood once w+1 further cells have arrived
        emit_cell = (in_row_reg != '0) && ((in_col_reg != '0) || (in_row_reg != ROW_W'(1)));

        if (out_col_reg == w_m1_reg)
        begin
            out_col_adv = '0;
            out_row_adv = ROW_W'(out_row_reg + 1'b1);
        end
        else
        begin
            out_col_adv = COORD_W'(out_col_reg + 1'b1);
            out_row_adv = out_row_reg;
        end

        push          = 1'b0;
        push_op.col   = in_col_reg;
        push_op.walk  = 1'b0;
        push_op.emit  = 1'b0;
        push_op.has_l = (out_col_reg != '0);
        push_op.has_r = (out_col_reg != w_m1_reg);
        push_op.has_d = (out_row_reg != '0);
        push_op.has_u = (out_row_reg != h_m1_reg);
        push_op.last  = (out_col_reg == w_m1_reg) && (out_row_reg == h_m1_reg);
        push_op.ox    = out_col_reg;
        push_op.oy    = out_row_reg;

        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_GRID_WIDTH:  w_m1_next = COORD_W'(clamp_m1(cfg_data, MAX_WIDTH));
                REG_GRID_HEIGHT: h_m1_next = ROW_W'(clamp_m1(cfg_data, MAX_HEIGHT));
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            full_next    = 1'b0;
            prime_next   = 1'b0;
        end
        else if (prime_reg)
        begin
            // single-row grid: one extra column step lines the window up
            if (!q_status.full)
            begin
                push        = 1'b1;
                in_col_next = col_inc;
                prime_next  = 1'b0;
            end
        end
        else if (accept)
        begin
            if (kind_t'(kind) == KIND_CELL && !full_reg)
            begin
                push         = 1'b1;
                push_op.walk = walkable;
                push_op.emit = emit_cell;
                in_col_next  = col_inc;
                if (col_wrap)
                begin
                    if (in_row_reg == h_m1_reg)
                    begin
                        in_row_next = '0;
                        full_next   = 1'b1;
                        prime_next  = (h_m1_reg == '0);
                    end
                    else
                    begin
                        in_row_next = ROW_W'(in_row_reg + 1'b1);
                    end
                end
                if (emit_cell)
                begin
                    out_col_next = out_col_adv;
                    out_row_next = out_row_adv;
                end
            end
            else if (kind_t'(kind) == KIND_DRAIN && full_reg)
            begin
                push         = 1'b1;
                push_op.emit = 1'b1;
                if (push_op.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    full_next    = 1'b0;
                end
                else
                begin
                    in_col_next  = col_inc;
                    out_col_next = out_col_adv;
                    out_row_next = out_row_adv;
                end
            end
        end
    end

endmodule

// ===== rtl/gwdm_queue.sv =====
// Short FIFO of column steps between the front and back ends.
// Depends on gwdm_pkg.
`timescale 1ns / 1ps

module gwdm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gwdm_pkg::op_t       push_op,
    input  logic                pop,
    output gwdm_pkg::op_t       head_op,
    output gwdm_pkg::q_status_t q_status
);
    import gwdm_pkg::*;

    op_t               entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        q_status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
        q_status.empty = (count_reg == '0);
        head_op        = entries_reg[rd_ptr_reg];
        wr_ptr_next    = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next    = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next     = (QPTR_W+1)'(count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ===== rtl/gwdm_back.sv =====
// Back end: two-row line store, 3x3 column window, mask logic and output register.
// Depends on gwdm_pkg.
`timescale 1ns / 1ps

module gwdm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  gwdm_pkg::op_t       head_op,
    input  gwdm_pkg::q_status_t q_status,
    output logic                pop,
    output logic                emit_fire,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [gwdm_pkg::OUT_W-1:0] cell_x,
    output logic [gwdm_pkg::OUT_W-1:0] cell_y,
    output logic [7:0]          directions,
    output logic                last_cell
);
    import gwdm_pkg::*;

    // column bits: row below, center row, row above
    localparam int DN  = 0;
    localparam int MID = 1;
    localparam int UP  = 2;

    typedef logic [2:0] col_t;

    // entry bit 1: two rows back, bit 0: previous row
    logic [1:0]       lb_mem [MAX_WIDTH];
    logic [1:0]       lb_rd_reg;
    logic [1:0]       lb_wdata;

    logic             b_valid_reg, b_valid_next;
    op_t              b_op_reg;
    col_t             win_a_reg, win_b_reg;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] cell_x_reg, cell_y_reg;
    logic [7:0]       dir_reg;
    logic             last_reg;

    logic             out_free;
    logic             b_fire;
    col_t             col_r;
    logic             step_l, step_r, step_d, step_u;
    logic [7:0]       dir;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        b_fire    = b_valid_reg && (!b_op_reg.emit || out_free);
        pop       = !q_status.empty && (!b_valid_reg || b_fire);
        emit_fire = b_fire && b_op_reg.emit;

        col_r[DN]  = lb_rd_reg[1];
        col_r[MID] = lb_rd_reg[0];
        col_r[UP]  = b_op_reg.walk;
        lb_wdata   = {lb_rd_reg[0], b_op_reg.walk};

        // left = older window column, center = newer, right = incoming
        step_l = b_op_reg.has_l && win_b_reg[MID];
        step_r = b_op_reg.has_r && col_r[MID];
        step_d = b_op_reg.has_d && win_a_reg[DN];
        step_u = b_op_reg.has_u && win_a_reg[UP];

        dir[0] = step_l;
        dir[1] = step_r;
        dir[2] = step_d;
        dir[3] = step_u;
        dir[4] = step_d && step_r && col_r[DN];
        dir[5] = step_d && step_l && win_b_reg[DN];
        dir[6] = step_u && step_r && col_r[UP];
        dir[7] = step_u && step_l && win_b_reg[UP];

        b_valid_next = pop ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);

        if (emit_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
            lb_mem[b_op_reg.col] <= lb_wdata;
        if (pop)
        begin
            if (b_fire && (b_op_reg.col == head_op.col))
                lb_rd_reg <= lb_wdata;
            else
                lb_rd_reg <= lb_mem[head_op.col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            b_op_reg <= head_op;
        if (b_fire)
        begin
            win_b_reg <= win_a_reg;
            win_a_reg <= col_r;
        end
        if (emit_fire)
        begin
            cell_x_reg <= OUT_W'(b_op_reg.ox);
            cell_y_reg <= OUT_W'(b_op_reg.oy);
            dir_reg    <= dir;
            last_reg   <= b_op_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_x     = cell_x_reg;
    assign cell_y     = cell_y_reg;
    assign directions = dir_reg;
    assign last_cell  = last_reg;

endmodule

// ===== rtl/grid_walkable_direction_mask.sv =====
// Path: a cell's mask passes the queue, the back-end step register and the output register
//   after the word that completes its 3x3 neighborhood (w+1 cells later in raster order,
//   or a drain word). Throughput: one word per cycle while in_ready is high; a single-row
//   grid takes one extra column step per frame in the front end to line up the column window.
// Reset: positions cleared, sizes 16x16, line store holds no reset value.
`timescale 1ns / 1ps

module grid_walkable_direction_mask (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gwdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gwdm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic                           walkable,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gwdm_pkg::OUT_W-1:0]     cell_x,
    output logic [gwdm_pkg::OUT_W-1:0]     cell_y,
    output logic [7:0]                     directions,
    output logic                           last_cell
);
    import gwdm_pkg::*;

    logic      q_push;
    op_t       q_push_op;
    logic      q_pop;
    op_t       q_head_op;
    q_status_t q_status;
    logic      emit_fire;

    gwdm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .walkable (walkable),
        .q_status (q_status),
        .push     (q_push),
        .push_op  (q_push_op)
    );

    gwdm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .head_op (q_head_op),
        .q_status(q_status)
    );

    gwdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_op   (q_head_op),
        .q_status  (q_status),
        .pop       (q_pop),
        .emit_fire (emit_fire),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .directions(directions),
        .last_cell (last_cell)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_emit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid)
        else $error("mask word lost before output register");

endmodule
